// File: rtl/alm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

  localparam int unsigned CAPACITY = 255;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned DEPTH    = CAPACITY + 1;

  // request codes
  localparam logic [2:0] FN_APPEND  = 3'd0;
  localparam logic [2:0] FN_INS_AFT = 3'd1;
  localparam logic [2:0] FN_INS_BEF = 3'd2;
  localparam logic [2:0] FN_DELETE  = 3'd3;
  localparam logic [2:0] FN_FIND_V  = 3'd4;
  localparam logic [2:0] FN_FIND_P  = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_BADSLOT  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [2:0]        func;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] value;
    logic [SLOT_W-1:0] position;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] result_slot;
    logic [SLOT_W-1:0] element_count;
  } rsp_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_CHK   = 9'b0_0000_0010,
    S_ALLOC = 9'b0_0000_0100,
    S_LINK  = 9'b0_0000_1000,
    S_DEL   = 9'b0_0001_0000,
    S_DEL2  = 9'b0_0010_0000,
    S_WALK  = 9'b0_0100_0000,
    S_DONE  = 9'b0_1000_0000,
    S_INIT  = 9'b1_0000_0000
  } state_e;

endpackage

`default_nettype wire

// File: rtl/array_linked_list_manager.sv
`timescale 1ns / 1ps
`default_nettype none

// Doubly linked list of up to 255 elements kept in slot memories, with a
// chain of free slots. One request beat is taken at a time and gives one
// response beat: append at the tail, insert after or before a slot, delete
// a slot, find the first slot holding a value, or find the slot at a
// one-based list position. Next links, previous links, in-use marks and data
// words live in four single-port-read synchronous memories. After reset a
// clearing pass over every slot rebuilds the free chain and clears links and
// marks; the request side stalls until it ends. A request is checked first;
// append and insert then allocate a slot and link it (append to an empty
// list skips the link step), delete unlinks and then frees the slot, and
// find requests walk the list one element per step, with a memory read of
// data and next link per step. The response sits in an output register, so
// a new request is taken while it waits.
module array_linked_list_manager (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire alm_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output alm_pkg::rsp_t      out_data_o
);

  localparam int unsigned SW = alm_pkg::SLOT_W;
  localparam logic [SW-1:0] CAP = SW'(alm_pkg::CAPACITY);

  // reset content of the next link memory: free chain i to i+1
  function automatic logic [SW-1:0] next_rst(input logic [SW-1:0] a);
    logic [SW-1:0] r;
    r = (a == '0 || a == CAP) ? '0 : a + SW'(1);
    return r;
  endfunction

  // slot memories
  logic [SW-1:0]              nxt_mem [alm_pkg::DEPTH];
  logic [SW-1:0]              prv_mem [alm_pkg::DEPTH];
  logic                       usd_mem [alm_pkg::DEPTH];
  logic [alm_pkg::DATA_W-1:0] dat_mem [alm_pkg::DEPTH];

  // memory ports
  logic                       nxt_we, prv_we, usd_we, dat_we;
  logic [SW-1:0]              nxt_wa, prv_wa, usd_wa, dat_wa;
  logic [SW-1:0]              nxt_wd, prv_wd;
  logic                       usd_wd;
  logic [alm_pkg::DATA_W-1:0] dat_wd;
  logic [SW-1:0]              nxt_ra, prv_ra, usd_ra, dat_ra;

  // registered read data
  logic [SW-1:0]              nxt_rd_q, prv_rd_q;
  logic                       usd_rd_q;
  logic [alm_pkg::DATA_W-1:0] dat_rd_q;
  logic [SW-1:0]              nxt_val, prv_val;
  logic                       usd_val;

  // control state
  alm_pkg::state_e state_q, state_d;
  logic [SW-1:0]   head_q, head_d, tail_q, tail_d, fh_q, fh_d, cnt_q, cnt_d;
  logic [SW-1:0]   clr_q, clr_d;
  logic            out_valid_q, out_valid_d;

  // per-request working registers
  alm_pkg::req_t req_q, req_d;
  alm_pkg::rsp_t out_q, out_d;
  logic [SW-1:0] ns_q, ns_d, ps_q, ps_d, n_q, n_d, it_q, it_d, k_q, k_d;
  logic [SW-1:0] res_q, res_d;
  logic [2:0]    st_q, st_d;

  logic full, tgt_ok, is_find;

  // memory arrays, read-before-write
  always_ff @(posedge clk_i) begin
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (usd_we) usd_mem[usd_wa] <= usd_wd;
    if (dat_we) dat_mem[dat_wa] <= dat_wd;
    nxt_rd_q <= nxt_mem[nxt_ra];
    prv_rd_q <= prv_mem[prv_ra];
    usd_rd_q <= usd_mem[usd_ra];
    dat_rd_q <= dat_mem[dat_ra];
  end

  assign nxt_val = nxt_rd_q;
  assign prv_val = prv_rd_q;
  assign usd_val = usd_rd_q;

  assign full    = (cnt_q == CAP) || (fh_q == '0);
  assign tgt_ok  = (req_q.slot != '0) && usd_val;
  assign is_find = (req_q.func == alm_pkg::FN_FIND_V) || (req_q.func == alm_pkg::FN_FIND_P);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fh_d        = fh_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    req_d       = req_q;
    ns_d        = ns_q;
    ps_d        = ps_q;
    n_d         = n_q;
    it_d        = it_q;
    k_d         = k_q;
    st_d        = st_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    prv_we = 1'b0; prv_wa = '0; prv_wd = '0;
    usd_we = 1'b0; usd_wa = '0; usd_wd = 1'b0;
    dat_we = 1'b0; dat_wa = '0; dat_wd = req_q.value;
    nxt_ra = req_q.slot;
    prv_ra = req_q.slot;
    usd_ra = req_q.slot;
    dat_ra = it_q;

    case (state_q)
      alm_pkg::S_INIT: begin
        // clearing pass: one entry per cycle, free chain rebuilt
        nxt_we = 1'b1; nxt_wa = clr_q; nxt_wd = next_rst(clr_q);
        prv_we = 1'b1; prv_wa = clr_q;
        usd_we = 1'b1; usd_wa = clr_q;
        clr_d  = clr_q + SW'(1);
        if (clr_q == SW'(alm_pkg::DEPTH - 1)) state_d = alm_pkg::S_IDLE;
      end

      alm_pkg::S_IDLE: begin
        // look up the target slot's links and mark right away
        nxt_ra = in_data_i.slot;
        prv_ra = in_data_i.slot;
        usd_ra = in_data_i.slot;
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = alm_pkg::S_CHK;
        end
      end

      alm_pkg::S_CHK: begin
        ns_d   = nxt_val;
        ps_d   = prv_val;
        res_d  = '0;
        st_d   = alm_pkg::ST_OK;
        // free slot's link for allocation, or the head for a walk
        nxt_ra = is_find ? head_q : fh_q;
        dat_ra = head_q;
        it_d   = head_q;
        state_d = alm_pkg::S_DONE;
        case (req_q.func)
          alm_pkg::FN_APPEND: begin
            if (full) st_d = alm_pkg::ST_FULL;
            else state_d = alm_pkg::S_ALLOC;
          end
          alm_pkg::FN_INS_AFT, alm_pkg::FN_INS_BEF: begin
            if (!tgt_ok) st_d = alm_pkg::ST_BADSLOT;
            else if (full) st_d = alm_pkg::ST_FULL;
            else state_d = alm_pkg::S_ALLOC;
          end
          alm_pkg::FN_DELETE: begin
            if (cnt_q == '0) st_d = alm_pkg::ST_EMPTY;
            else if (!tgt_ok) st_d = alm_pkg::ST_BADSLOT;
            else state_d = alm_pkg::S_DEL;
          end
          alm_pkg::FN_FIND_V: begin
            k_d = '0;
            if (cnt_q == '0) st_d = alm_pkg::ST_EMPTY;
            else state_d = alm_pkg::S_WALK;
          end
          alm_pkg::FN_FIND_P: begin
            k_d = SW'(1);
            if (cnt_q == '0) st_d = alm_pkg::ST_EMPTY;
            else if (req_q.position == '0 || req_q.position > cnt_q)
              st_d = alm_pkg::ST_NOTFOUND;
            else state_d = alm_pkg::S_WALK;
          end
          default: st_d = alm_pkg::ST_BADSLOT;
        endcase
      end

      alm_pkg::S_ALLOC: begin
        // pop the free chain and fill the new slot
        n_d    = fh_q;
        fh_d   = nxt_val;
        cnt_d  = cnt_q + SW'(1);
        res_d  = fh_q;
        dat_we = 1'b1; dat_wa = fh_q;
        usd_we = 1'b1; usd_wa = fh_q; usd_wd = 1'b1;
        nxt_we = 1'b1; nxt_wa = fh_q;
        prv_we = 1'b1; prv_wa = fh_q;
        state_d = alm_pkg::S_LINK;
        case (req_q.func)
          alm_pkg::FN_APPEND: begin
            nxt_wd = '0;
            prv_wd = tail_q;
            ps_d   = tail_q;
            tail_d = fh_q;
            if (tail_q == '0) begin
              head_d  = fh_q;
              state_d = alm_pkg::S_DONE;
            end
          end
          alm_pkg::FN_INS_AFT: begin
            nxt_wd = ns_q;
            prv_wd = req_q.slot;
            if (req_q.slot == tail_q) tail_d = fh_q;
          end
          default: begin
            nxt_wd = req_q.slot;
            prv_wd = ps_q;
            if (req_q.slot == head_q) head_d = fh_q;
          end
        endcase
      end

      alm_pkg::S_LINK: begin
        // hook the neighbors to the new slot
        state_d = alm_pkg::S_DONE;
        case (req_q.func)
          alm_pkg::FN_APPEND: begin
            nxt_we = 1'b1; nxt_wa = ps_q; nxt_wd = n_q;
          end
          alm_pkg::FN_INS_AFT: begin
            nxt_we = 1'b1; nxt_wa = req_q.slot; nxt_wd = n_q;
            if (tail_q != n_q) begin
              prv_we = 1'b1; prv_wa = ns_q; prv_wd = n_q;
            end
          end
          default: begin
            prv_we = 1'b1; prv_wa = req_q.slot; prv_wd = n_q;
            if (head_q != n_q) begin
              nxt_we = 1'b1; nxt_wa = ps_q; nxt_wd = n_q;
            end
          end
        endcase
      end

      alm_pkg::S_DEL: begin
        // unlink from neighbors
        if (req_q.slot == head_q) head_d = ns_q;
        else begin
          nxt_we = 1'b1; nxt_wa = ps_q; nxt_wd = ns_q;
        end
        if (req_q.slot == tail_q) tail_d = ps_q;
        else begin
          prv_we = 1'b1; prv_wa = ns_q; prv_wd = ps_q;
        end
        cnt_d   = cnt_q - SW'(1);
        res_d   = req_q.slot;
        state_d = alm_pkg::S_DEL2;
      end

      alm_pkg::S_DEL2: begin
        // push onto the free chain
        usd_we = 1'b1; usd_wa = req_q.slot; usd_wd = 1'b0;
        prv_we = 1'b1; prv_wa = req_q.slot; prv_wd = '0;
        nxt_we = 1'b1; nxt_wa = req_q.slot; nxt_wd = fh_q;
        fh_d    = req_q.slot;
        state_d = alm_pkg::S_DONE;
      end

      alm_pkg::S_WALK: begin
        // one element per cycle: data and next link of it_q are in hand
        nxt_ra = nxt_val;
        dat_ra = nxt_val;
        it_d   = nxt_val;
        k_d    = k_q + SW'(1);
        if (req_q.func == alm_pkg::FN_FIND_V) begin
          if (dat_rd_q == req_q.value) begin
            res_d   = it_q;
            state_d = alm_pkg::S_DONE;
          end else if ((({1'b0, k_q} + (SW+1)'(1)) >= {1'b0, cnt_q}) || nxt_val == '0) begin
            st_d    = alm_pkg::ST_NOTFOUND;
            state_d = alm_pkg::S_DONE;
          end
        end else begin
          if (k_q == req_q.position) begin
            res_d   = it_q;
            state_d = alm_pkg::S_DONE;
          end else if (nxt_val == '0) begin
            st_d    = alm_pkg::ST_NOTFOUND;
            state_d = alm_pkg::S_DONE;
          end
        end
      end

      alm_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status        = st_q;
          out_d.result_slot   = (st_q == alm_pkg::ST_OK) ? res_q : '0;
          out_d.element_count = cnt_q;
          out_valid_d         = 1'b1;
          state_d             = alm_pkg::S_IDLE;
        end
      end

      default: state_d = alm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alm_pkg::S_INIT;
      head_q      <= '0;
      tail_q      <= '0;
      fh_q        <= SW'(1);
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fh_q        <= fh_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    out_q <= out_d;
    ns_q  <= ns_d;
    ps_q  <= ps_d;
    n_q   <= n_d;
    it_q  <= it_d;
    k_q   <= k_d;
    st_q  <= st_d;
    res_q <= res_d;
  end

  assign in_stall_o  = (state_q != alm_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/alm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module alm_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire alm_pkg::req_t in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire alm_pkg::rsp_t out_data_o
);

  // a held response beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("response beat changed while stalled");

  // one request at a time: busy right after a request beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // failures carry no slot
  a_fail_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != alm_pkg::ST_OK |-> out_data_o.result_slot == '0)
    else $error("failed response with slot");

  // successes name a real slot
  a_ok_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == alm_pkg::ST_OK |-> out_data_o.result_slot != '0)
    else $error("ok response with slot zero");

  // no new response in the cycle right after a request beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 1'b1 |-> !$rose(out_valid_o))
    else $error("response too early");

endmodule

bind array_linked_list_manager alm_checker u_alm_checker (.*);

`default_nettype wire

// File: tb/array_linked_list_manager_tb.sv
`timescale 1ns / 1ps

module array_linked_list_manager_tb;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM       = 120;

  // expected responses and list mirror
  class list_scoreboard;
    logic [alm_pkg::DATA_W-1:0] data_q[alm_pkg::DEPTH];
    logic [alm_pkg::SLOT_W-1:0] next_q[alm_pkg::DEPTH];
    logic [alm_pkg::SLOT_W-1:0] prev_q[alm_pkg::DEPTH];
    bit                         used_q[alm_pkg::DEPTH];
    logic [alm_pkg::SLOT_W-1:0] head, tail, free_head;
    int unsigned                count;
    alm_pkg::rsp_t              pending_rsp[$];
    int unsigned                errors;

    function new();
      for (int i = 0; i < alm_pkg::DEPTH; i++) begin
        data_q[i] = '0;
        prev_q[i] = '0;
        used_q[i] = 0;
        next_q[i] = (i == 0 || i == alm_pkg::CAPACITY) ? 8'd0 : alm_pkg::SLOT_W'(i + 1);
      end
      head = 0;
      tail = 0;
      free_head = 1;
      count = 0;
      errors = 0;
    endfunction

    function bit live(logic [alm_pkg::SLOT_W-1:0] s);
      return s != 0 && s <= alm_pkg::CAPACITY && used_q[s];
    endfunction

    function logic [alm_pkg::SLOT_W-1:0] grab(logic [alm_pkg::DATA_W-1:0] v);
      logic [alm_pkg::SLOT_W-1:0] n;
      n = free_head;
      free_head = next_q[n];
      data_q[n] = v;
      used_q[n] = 1;
      count++;
      return n;
    endfunction

    // apply one request beat to the mirror, queue its response
    function void note_request(alm_pkg::req_t r);
      alm_pkg::rsp_t              rsp;
      logic [alm_pkg::SLOT_W-1:0] n, s, it;
      logic [2:0]                 st;
      st = alm_pkg::ST_OK;
      n = '0;
      s = r.slot;
      case (r.func)
        alm_pkg::FN_APPEND: begin
          if (count >= alm_pkg::CAPACITY) st = alm_pkg::ST_FULL;
          else begin
            n = grab(r.value);
            next_q[n] = 0;
            prev_q[n] = tail;
            if (tail == 0) head = n;
            else next_q[tail] = n;
            tail = n;
          end
        end
        alm_pkg::FN_INS_AFT: begin
          if (!live(s)) st = alm_pkg::ST_BADSLOT;
          else if (count >= alm_pkg::CAPACITY) st = alm_pkg::ST_FULL;
          else begin
            n = grab(r.value);
            prev_q[n] = s;
            next_q[n] = next_q[s];
            if (s == tail) tail = n;
            else prev_q[next_q[s]] = n;
            next_q[s] = n;
          end
        end
        alm_pkg::FN_INS_BEF: begin
          if (!live(s)) st = alm_pkg::ST_BADSLOT;
          else if (count >= alm_pkg::CAPACITY) st = alm_pkg::ST_FULL;
          else begin
            n = grab(r.value);
            next_q[n] = s;
            prev_q[n] = prev_q[s];
            if (s == head) head = n;
            else next_q[prev_q[s]] = n;
            prev_q[s] = n;
          end
        end
        alm_pkg::FN_DELETE: begin
          if (count == 0) st = alm_pkg::ST_EMPTY;
          else if (!live(s)) st = alm_pkg::ST_BADSLOT;
          else begin
            if (s == head) head = next_q[s];
            else next_q[prev_q[s]] = next_q[s];
            if (s == tail) tail = prev_q[s];
            else prev_q[next_q[s]] = prev_q[s];
            data_q[s] = '0;
            used_q[s] = 0;
            prev_q[s] = 0;
            next_q[s] = free_head;
            free_head = s;
            count--;
            n = s;
          end
        end
        alm_pkg::FN_FIND_V: begin
          if (count == 0) st = alm_pkg::ST_EMPTY;
          else begin
            st = alm_pkg::ST_NOTFOUND;
            it = head;
            for (int k = 0; k < count && it != 0; k++) begin
              if (data_q[it] == r.value) begin
                st = alm_pkg::ST_OK;
                n = it;
                break;
              end
              it = next_q[it];
            end
          end
        end
        alm_pkg::FN_FIND_P: begin
          if (count == 0) st = alm_pkg::ST_EMPTY;
          else if (r.position == 0 || r.position > count) st = alm_pkg::ST_NOTFOUND;
          else begin
            it = head;
            for (int k = 1; k < r.position && it != 0; k++) it = next_q[it];
            if (it == 0) st = alm_pkg::ST_NOTFOUND;
            else n = it;
          end
        end
        default: st = alm_pkg::ST_BADSLOT;
      endcase
      rsp.status = st;
      rsp.result_slot = (st == alm_pkg::ST_OK) ? n : '0;
      rsp.element_count = alm_pkg::SLOT_W'(count);
      pending_rsp.push_back(rsp);
    endfunction

    function void check_response(alm_pkg::rsp_t got);
      alm_pkg::rsp_t want;
      if (pending_rsp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response beat %p", got);
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status || got.result_slot !== want.result_slot ||
          got.element_count !== want.element_count) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected st=%0d slot=%0d cnt=%0d, got st=%0d slot=%0d cnt=%0d",
                   want.status, want.result_slot, want.element_count,
                   got.status, got.result_slot, got.element_count);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  alm_pkg::req_t in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b1;
  alm_pkg::rsp_t out_data;

  list_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  bit          stim_done = 0;
  bit          hold_off = 0;

  always #5 clk = ~clk;

  array_linked_list_manager DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // mostly short gaps, now and then a long one, sometimes none
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // monitor: note requests and check responses on accepted beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_response(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off while the sender keeps going
  initial begin
    int unsigned g;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 300; i++) @(posedge clk);
        hold_off = 0;
        out_stall <= 1'b0;
      end else begin
        g = stim_done ? 0 : gap_len();
        out_stall <= (g != 0);
        for (int i = 1; i < g; i++) @(posedge clk);
      end
    end
  end

  // offer one beat and hold it until accepted
  task automatic send_request(logic [2:0] f, logic [alm_pkg::SLOT_W-1:0] s,
                              logic [alm_pkg::DATA_W-1:0] v,
                              logic [alm_pkg::SLOT_W-1:0] p);
    alm_pkg::req_t r;
    int unsigned g;
    r.func = f;
    r.slot = s;
    r.value = v;
    r.position = p;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // pick a live slot, or any slot now and then
  function automatic logic [alm_pkg::SLOT_W-1:0] pick_slot();
    logic [alm_pkg::SLOT_W-1:0] s;
    if (sb.count != 0 && $urandom_range(0, 9) != 0) begin
      for (int t = 0; t < 64; t++) begin
        s = alm_pkg::SLOT_W'($urandom_range(1, alm_pkg::CAPACITY));
        if (sb.used_q[s]) return s;
      end
      return sb.head;
    end
    return alm_pkg::SLOT_W'($urandom_range(0, 255));
  endfunction

  // stored word: mostly picked from a small pool so finds hit often
  function automatic logic [alm_pkg::DATA_W-1:0] pick_value();
    if ($urandom_range(0, 2) == 0) return $urandom();
    return alm_pkg::DATA_W'($urandom_range(0, 15));
  endfunction

  initial begin
    logic [2:0] f;
    int unsigned r;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list cases, undefined codes, field extremes
    send_request(alm_pkg::FN_DELETE, 8'd1, '0, '0);
    send_request(alm_pkg::FN_FIND_V, 8'd0, '0, 8'd1);
    send_request(alm_pkg::FN_FIND_P, 8'd0, '0, 8'd1);
    send_request(alm_pkg::FN_INS_AFT, 8'd1, 32'd5, '0);
    send_request(3'd6, 8'hff, '1, 8'hff);
    send_request(3'd7, 8'h00, '0, 8'h00);
    send_request(alm_pkg::FN_APPEND, 8'd0, '1, '0);
    send_request(alm_pkg::FN_APPEND, 8'd0, 32'd0, '0);
    send_request(alm_pkg::FN_INS_AFT, 8'd2, 32'h5a5a_a5a5, '0);
    send_request(alm_pkg::FN_INS_BEF, 8'd1, 32'ha5a5_5a5a, '0);
    send_request(alm_pkg::FN_INS_BEF, 8'hff, 32'd1, '0);
    send_request(alm_pkg::FN_FIND_V, 8'd0, 32'ha5a5_5a5a, '0);
    send_request(alm_pkg::FN_FIND_V, 8'd0, 32'h5a5a_a5a5, '0);
    send_request(alm_pkg::FN_FIND_V, 8'd0, 32'd77, '0);
    send_request(alm_pkg::FN_FIND_P, 8'd0, '0, 8'd0);
    send_request(alm_pkg::FN_FIND_P, 8'd0, '0, 8'd4);
    send_request(alm_pkg::FN_FIND_P, 8'd0, '0, 8'd5);
    send_request(alm_pkg::FN_FIND_P, 8'd0, '0, 8'hff);
    send_request(alm_pkg::FN_DELETE, 8'd3, '0, '0);
    send_request(alm_pkg::FN_DELETE, 8'd3, '0, '0);
    send_request(alm_pkg::FN_DELETE, 8'd0, '0, '0);
    send_request(alm_pkg::FN_DELETE, 8'd2, '0, '0);

    // fill to capacity, hit full on every insert form, long receiver hold-off
    hold_off = 1;
    while (sb.count < alm_pkg::CAPACITY)
      send_request(alm_pkg::FN_APPEND, '0, pick_value(), '0);
    send_request(alm_pkg::FN_APPEND, '0, 32'd9, '0);
    send_request(alm_pkg::FN_INS_AFT, 8'd1, 32'd9, '0);
    send_request(alm_pkg::FN_INS_BEF, 8'd1, 32'd9, '0);
    send_request(alm_pkg::FN_FIND_P, '0, '0, 8'hff);
    send_request(alm_pkg::FN_FIND_V, '0, 32'hdead_beef, '0);

    // random mix of all request kinds and undefined codes
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) f = alm_pkg::FN_APPEND;
      else if (r < 32) f = alm_pkg::FN_INS_AFT;
      else if (r < 44) f = alm_pkg::FN_INS_BEF;
      else if (r < 70) f = alm_pkg::FN_DELETE;
      else if (r < 83) f = alm_pkg::FN_FIND_V;
      else if (r < 97) f = alm_pkg::FN_FIND_P;
      else f = 3'($urandom_range(6, 7));
      send_request(f, pick_slot(), pick_value(),
                   $urandom_range(0, 3) == 0 ? 8'($urandom()) :
                   8'($urandom_range(0, sb.count + 1)));
    end
    in_valid <= 1'b0;
    stim_done = 1;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
